[hw/rtl/write_only_oram_store_macros.svh]
// ----------------------------------------------------------------------------
// write_only_oram_store_macros
// Assertion macros shared by the write-only oblivious store RTL.
// ----------------------------------------------------------------------------
`ifndef WRITE_ONLY_ORAM_STORE_MACROS_SVH
`define WRITE_ONLY_ORAM_STORE_MACROS_SVH

`ifndef SYNTHESIS

// Check a property on every rising edge, held off while reset is low.
`define WOOS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("write_only_oram_store: assertion failed");

// Check a property on every rising edge, reset included.
`define WOOS_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("write_only_oram_store: assertion failed");

`else

`define WOOS_ASSERT(lbl, clk, rst_n, prop)
`define WOOS_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

[hw/rtl/woos_pkg.sv]
// ----------------------------------------------------------------------------
// woos_pkg
// Types and constants of the write-only oblivious store.
// ----------------------------------------------------------------------------
package woos_pkg;

    localparam int DEF_LOGICAL_BLOCKS = 64;
    localparam int DEF_HOLDING_BLOCKS = 8;

    localparam int ADDR_W = 6;
    localparam int DATA_W = 32;

    localparam logic REQ_READ  = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD_MAP,
        ST_RD_DATA,
        ST_REFRESH
    } t_state;

endpackage

[hw/rtl/woos_ram.sv]
// ----------------------------------------------------------------------------
// woos_ram
// Simple dual-port synchronous RAM: one write port, one read port with a
// registered read that updates only when enabled.
// ----------------------------------------------------------------------------
module woos_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Hold the last read word until the next enabled read.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/write_only_oram_store.sv]
// ----------------------------------------------------------------------------
// write_only_oram_store
// Write-only oblivious store: main and holding blocks plus a location map.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_ready) carries one request item:
// i_req_type (0 read, 1 write), i_address, i_write_data. Output channel
// (o_out_valid / i_out_ready) carries one o_read_data item per read; a write
// gives no item.
// Read: the map lookup and the store lookup are each a registered memory
// read, then the word is loaded into the output register, and no new item
// is taken before that. A read with an address not below LOGICAL_BLOCKS
// returns zero. Write: K = LOGICAL_BLOCKS / HOLDING_BLOCKS (8 by default).
// The accept cycle writes the holding block and its map entry; the refresh
// of K main blocks then runs as a three-stage map-read, store-read,
// write-back pipeline, one block entering per cycle, and no new item is
// taken until it is done. A write with an address out of range is dropped.
// Reset: clearing all LOGICAL_BLOCKS + HOLDING_BLOCKS entries zeroes the
// store and loads the identity map; o_in_ready stays low until it is done.
// Stall: the output register parts the two sides, so new items are taken
// while a result waits; a read that finds the register still full holds in
// its last step until the receiver takes the waiting item.
// ----------------------------------------------------------------------------
module write_only_oram_store #(
    parameter int LOGICAL_BLOCKS = woos_pkg::DEF_LOGICAL_BLOCKS,
    parameter int HOLDING_BLOCKS = woos_pkg::DEF_HOLDING_BLOCKS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic                               i_req_type,
    input  logic [woos_pkg::ADDR_W-1:0]        i_address,
    input  logic signed [woos_pkg::DATA_W-1:0] i_write_data,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic signed [woos_pkg::DATA_W-1:0] o_read_data
);

    import woos_pkg::*;

`include "write_only_oram_store_macros.svh"

    localparam int N  = LOGICAL_BLOCKS;
    localparam int M  = HOLDING_BLOCKS;
    localparam int T  = N + M;
    localparam int K  = N / M;
    localparam int AW = $clog2(N);
    localparam int PW = $clog2(T);
    localparam int HW = (M > 1) ? $clog2(M) : 1;
    localparam int KW = $clog2(K + 2);
    localparam bit HAS_REFRESH = (K > 0);

    // Memory ports
    logic          map_we;
    logic [AW-1:0] map_waddr;
    logic [PW-1:0] map_wdata;
    logic          map_re;
    logic [AW-1:0] map_raddr;
    logic [PW-1:0] map_rdata;

    logic              st_we;
    logic [PW-1:0]     st_waddr;
    logic [DATA_W-1:0] st_wdata;
    logic              st_re;
    logic [PW-1:0]     st_raddr;
    logic [DATA_W-1:0] st_rdata;

    woos_ram #(
        .DEPTH (N),
        .WIDTH (PW)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (map_we),
        .i_waddr (map_waddr),
        .i_wdata (map_wdata),
        .i_re    (map_re),
        .i_raddr (map_raddr),
        .o_rdata (map_rdata)
    );

    woos_ram #(
        .DEPTH (T),
        .WIDTH (DATA_W)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (st_wdata),
        .i_re    (st_re),
        .i_raddr (st_raddr),
        .o_rdata (st_rdata)
    );

    // Control state
    t_state               r_state,     n_state;
    logic [PW-1:0]        r_clr,       n_clr;
    logic [AW-1:0]        r_cnt,       n_cnt;      // write counter mod N
    logic [HW-1:0]        r_hold,      n_hold;     // write counter mod M
    logic [AW-1:0]        r_start,     n_start;    // (count * K) mod N
    logic [AW-1:0]        r_ref,       n_ref;      // next block to refresh
    logic [KW-1:0]        r_iss,       n_iss;      // refresh blocks issued
    logic                 r_v1,        n_v1;
    logic                 r_v2,        n_v2;
    logic [AW-1:0]        r_a1,        n_a1;
    logic [AW-1:0]        r_a2,        n_a2;
    logic                 r_rd_ok,     n_rd_ok;
    logic                 r_out_valid, n_out_valid;
    logic signed [DATA_W-1:0] r_out_data, n_out_data;

    logic          accept;
    logic          addr_ok;
    logic          wr_go;
    logic          issue;
    logic [PW-1:0] hold_phys;
    logic [AW:0]   start_sum;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign accept      = i_in_valid && o_in_ready;
    assign addr_ok     = (32'(i_address) < N);
    assign wr_go       = accept && (i_req_type == REQ_WRITE) && addr_ok;
    assign hold_phys   = PW'(N) + PW'(r_hold);
    assign start_sum   = {1'b0, r_start} + (AW+1)'(K);
    assign issue       = (r_iss != KW'(K));
    assign o_out_valid = r_out_valid;
    assign o_read_data = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_cnt       <= '0;
            r_hold      <= '0;
            r_start     <= '0;
            r_ref       <= '0;
            r_iss       <= '0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_rd_ok     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_cnt       <= n_cnt;
            r_hold      <= n_hold;
            r_start     <= n_start;
            r_ref       <= n_ref;
            r_iss       <= n_iss;
            r_v1        <= n_v1;
            r_v2        <= n_v2;
            r_rd_ok     <= n_rd_ok;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_a1       <= n_a1;
        r_a2       <= n_a2;
        r_out_data <= n_out_data;
    end

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_cnt       = r_cnt;
        n_hold      = r_hold;
        n_start     = r_start;
        n_ref       = r_ref;
        n_iss       = r_iss;
        n_v1        = r_v1;
        n_v2        = r_v2;
        n_a1        = r_a1;
        n_a2        = r_a2;
        n_rd_ok     = r_rd_ok;
        n_out_data  = r_out_data;
        n_out_valid = r_out_valid;

        map_we    = 1'b0;
        map_waddr = '0;
        map_wdata = '0;
        map_re    = 1'b0;
        map_raddr = '0;
        st_we     = 1'b0;
        st_waddr  = '0;
        st_wdata  = '0;
        st_re     = 1'b0;
        st_raddr  = '0;

        // Drop the waiting result once the receiver takes it.
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_CLEAR: begin
                // Zero one store entry a cycle, loading the identity map below N.
                st_we    = 1'b1;
                st_waddr = r_clr;
                st_wdata = '0;
                if (32'(r_clr) < N) begin
                    map_we    = 1'b1;
                    map_waddr = AW'(r_clr);
                    map_wdata = r_clr;
                end
                if (r_clr == PW'(T - 1)) begin
                    n_state = ST_IDLE;
                end else begin
                    n_clr = r_clr + 1'b1;
                end
            end

            ST_IDLE: begin
                if (accept && (i_req_type == REQ_WRITE)) begin
                    if (addr_ok) begin
                        // Park the word in the current holding block.
                        st_we     = 1'b1;
                        st_waddr  = hold_phys;
                        st_wdata  = i_write_data;
                        map_we    = 1'b1;
                        map_waddr = AW'(i_address);
                        map_wdata = hold_phys;
                        n_ref     = r_start;
                        n_iss     = '0;
                        // Advance the counters; all wrap together at N.
                        if (r_cnt == AW'(N - 1)) begin
                            n_cnt   = '0;
                            n_hold  = '0;
                            n_start = '0;
                        end else begin
                            n_cnt  = r_cnt + 1'b1;
                            n_hold = (r_hold == HW'(M - 1)) ? '0 : r_hold + 1'b1;
                            n_start = (start_sum >= (AW+1)'(N))
                                ? AW'(start_sum - (AW+1)'(N)) : AW'(start_sum);
                        end
                        if (HAS_REFRESH) begin
                            n_state = ST_REFRESH;
                        end
                    end
                end else if (accept) begin
                    map_re    = 1'b1;
                    map_raddr = AW'(i_address);
                    n_rd_ok   = addr_ok;
                    n_state   = ST_RD_MAP;
                end
            end

            ST_RD_MAP: begin
                st_re    = 1'b1;
                st_raddr = map_rdata;
                n_state  = ST_RD_DATA;
            end

            ST_RD_DATA: begin
                // Hold here while the output register is still occupied.
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_rd_ok ? $signed(st_rdata) : '0;
                    n_state     = ST_IDLE;
                end
            end

            ST_REFRESH: begin
                // Stage 0: read the map entry of the next block.
                if (issue) begin
                    map_re    = 1'b1;
                    map_raddr = r_ref;
                    n_ref     = (r_ref == AW'(N - 1)) ? '0 : r_ref + 1'b1;
                    n_iss     = r_iss + 1'b1;
                end
                n_v1 = issue;
                n_a1 = r_ref;
                // Stage 1: read the block the map points at.
                if (r_v1) begin
                    st_re    = 1'b1;
                    st_raddr = map_rdata;
                end
                n_v2 = r_v1;
                n_a2 = r_a1;
                // Stage 2: write the latest word home and reset its map entry.
                if (r_v2) begin
                    st_we     = 1'b1;
                    st_waddr  = PW'(r_a2);
                    st_wdata  = st_rdata;
                    map_we    = 1'b1;
                    map_waddr = r_a2;
                    map_wdata = PW'(r_a2);
                end
                if (!issue && !r_v1) begin
                    n_state = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // A main block maps either to itself or to a holding block.
    `WOOS_ASSERT(a_map_target, i_clk, i_rst_n,
        r_v1 |-> ((map_rdata == PW'(r_a1)) || (32'(map_rdata) >= N)))
    // A read never overwrites a result that is still waiting.
    `WOOS_ASSERT(a_out_hold, i_clk, i_rst_n,
        (r_state == ST_RD_DATA && r_out_valid && !i_out_ready) |=>
            (r_state == ST_RD_DATA))
    // The write counter steps by one on each in-range write that does not wrap.
    `WOOS_ASSERT(a_cnt_step, i_clk, i_rst_n,
        (wr_go && r_cnt != AW'(N - 1)) |=> (r_cnt == $past(r_cnt) + AW'(1)))
    // All counters wrap together at N.
    `WOOS_ASSERT(a_cnt_wrap, i_clk, i_rst_n,
        (wr_go && r_cnt == AW'(N - 1)) |=>
            (r_cnt == '0 && r_hold == '0 && r_start == '0))

endmodule
